>>> src/assert_macros.svh
// Assertion macros shared by the shell sort RTL.
// Expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define SSC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("never-condition hit");

// Antecedent implies consequent in the same cycle.
`define SSC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

>>> src/ssc_pkg.sv
// Shared constants and types for the shell sort block.
// No dependencies.
package ssc_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int DATA_W       = 32;
  localparam int MOVE_W       = 18;
  localparam int CMPT_W       = 16;
  localparam int OUT_W        = 72;

  localparam logic [MOVE_W-1:0] MOVE_MAX = '1;
  localparam logic [CMPT_W-1:0] CMPT_MAX = '1;

  // 5*g/11 == (g*1865) >> 12, exact for g up to 64
  localparam int RECIP_W = 11;
  localparam logic [RECIP_W-1:0] GAP_RECIP = 11'd1865;
  localparam int GAP_SHIFT = 12;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  idx_t;

  typedef struct packed {
    logic clear;
    logic cmp;
    logic swap;
    logic drop;
  } stats_ctl_t;

endpackage

>>> src/ssc_mem.sv
// Element store: one write port, two registered read ports.
// Depends on ssc_pkg.
module ssc_mem
  import ssc_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  data_t wr_data,
  input  logic  rd_en,
  input  addr_t rd_addr_a,
  input  addr_t rd_addr_b,
  output data_t rd_data_a,
  output data_t rd_data_b
);

  data_t mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> src/ssc_cmp.sv
// Shared compare unit with saturating compare/move counters and overflow flag.
// Depends on ssc_pkg.
module ssc_cmp
  import ssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  stats_ctl_t        ctl,
  input  data_t             a,
  input  data_t             b,
  output logic              lt,
  output logic [MOVE_W-1:0] move_total,
  output logic [CMPT_W-1:0] compare_total,
  output logic              overflow
);

  logic [MOVE_W:0] move_sum;

  assign lt       = a < b;
  assign move_sum = {1'b0, move_total} + (MOVE_W + 1)'(3);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      move_total    <= '0;
      compare_total <= '0;
      overflow      <= 1'b0;
    end else begin
      if (ctl.cmp && compare_total != CMPT_MAX) begin
        compare_total <= compare_total + CMPT_W'(1);
      end
      if (ctl.swap) begin
        move_total <= (move_sum > {1'b0, MOVE_MAX}) ? MOVE_MAX : move_sum[MOVE_W-1:0];
      end
      if (ctl.drop) begin
        overflow <= 1'b1;
      end
    end
  end

  `include "assert_macros.svh"

  `SSC_ASSERT_IMPLY(a_cmp_mono, !ctl.clear && $past(!rst && !ctl.clear), compare_total >= $past(compare_total))
  `SSC_ASSERT_IMPLY(a_move_mono, !ctl.clear && $past(!rst && !ctl.clear), move_total >= $past(move_total))
  `SSC_ASSERT_IMPLY(a_swap_after_cmp, ctl.swap, compare_total != '0)

endmodule

>>> src/shell_sort_with_counts.sv
// Top level of the shell sort block: load/sort/emit sequencer.
// Depends on ssc_pkg, ssc_mem, ssc_cmp and assert_macros.svh.
//
// Beats load one per cycle into a 64-entry store until a beat with tlast;
// beats past 64 are dropped and flagged on tuser of the final output beat.
// The run is then sorted in place with Gonnet gaps (gap = 5*gap/11, 1 once
// gap <= 2) using one compare unit over the store's two read ports: each
// visited pair is read (ST_RD), compared (ST_CMP) and, if it swaps, written
// back (ST_WR1, ST_WR2) before ST_STEP; each chain starts in ST_ISTART and
// each pass begins with a gap update in ST_GAP. The compare count C depends
// on n only (3553 at n = 64).
// Each result beat is read (ST_ORD), registered (ST_OLD) and held in
// ST_OWAIT until taken before the next is read; the input is not ready from
// the last input beat until the last output beat is taken. The move and
// compare totals ride on the final output beat only.
`include "assert_macros.svh"

module shell_sort_with_counts
  import ssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,  // [31:0] value
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // [31:0] sorted_value, [49:32] move_total,
                                     // [65:50] compare_total, [71:66] zero
  output logic             m_tuser,  // [0] overflow
  output logic             m_tlast
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_GAP, ST_ISTART, ST_RD, ST_CMP, ST_WR1, ST_WR2, ST_STEP,
    ST_ORD, ST_OLD, ST_OWAIT
  } state_t;

  state_t state;
  idx_t   count, n, gap, i, j, k;
  idx_t   jg, count_inc, gap_next;
  logic   has_room;
  logic   out_fin;
  logic [CNT_W+RECIP_W-1:0] gap_prod;

  logic       wr_en, rd_en;
  addr_t      wr_addr, rd_addr_a;
  data_t      wr_data, rd_a, rd_b;
  stats_ctl_t sctl;
  logic       lt, overflow;
  logic [MOVE_W-1:0] move_total;
  logic [CMPT_W-1:0] compare_total;

  assign s_tready  = (state == ST_LOAD);
  assign has_room  = count < CNT_W'(MAX_ELEMENTS);
  assign count_inc = has_room ? count + CNT_W'(1) : count;
  assign jg        = j - gap;
  assign gap_prod  = {{RECIP_W{1'b0}}, gap} * {{CNT_W{1'b0}}, GAP_RECIP};
  assign gap_next  = (gap <= CNT_W'(2)) ? CNT_W'(1) : {1'b0, gap_prod[GAP_SHIFT +: ADDR_W]};
  assign out_fin   = (k == n - CNT_W'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = s_tdata;
    unique case (state)
      ST_LOAD: wr_en = s_tvalid && has_room;
      ST_WR1: begin
        wr_en   = 1'b1;
        wr_addr = j[ADDR_W-1:0];
        wr_data = rd_b;
      end
      ST_WR2: begin
        wr_en   = 1'b1;
        wr_addr = jg[ADDR_W-1:0];
        wr_data = rd_a;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign rd_en     = (state == ST_RD) || (state == ST_ORD);
  assign rd_addr_a = (state == ST_ORD) ? k[ADDR_W-1:0] : j[ADDR_W-1:0];

  assign sctl.clear = (state == ST_OWAIT) && m_tready && m_tlast;
  assign sctl.cmp   = (state == ST_CMP);
  assign sctl.swap  = (state == ST_WR1);
  assign sctl.drop  = (state == ST_LOAD) && s_tvalid && !has_room;

  ssc_mem u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (jg[ADDR_W-1:0]),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  ssc_cmp u_cmp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (sctl),
    .a             (rd_a),
    .b             (rd_b),
    .lt            (lt),
    .move_total    (move_total),
    .compare_total (compare_total),
    .overflow      (overflow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_tvalid) begin
            count <= count_inc;
            if (s_tlast) begin
              n     <= count_inc;
              gap   <= count_inc;
              state <= ST_GAP;
            end
          end
        end
        ST_GAP: begin
          if (gap <= CNT_W'(1)) begin
            k     <= '0;
            state <= ST_ORD;
          end else begin
            gap   <= gap_next;
            i     <= gap_next;
            state <= ST_ISTART;
          end
        end
        ST_ISTART: begin
          if (i < n) begin
            j     <= i;
            state <= ST_RD;
          end else begin
            state <= ST_GAP;
          end
        end
        ST_RD:  state <= ST_CMP;
        ST_CMP: state <= lt ? ST_WR1 : ST_STEP;
        ST_WR1: state <= ST_WR2;
        ST_WR2: state <= ST_STEP;
        ST_STEP: begin
          if (jg >= gap) begin
            j     <= jg;
            state <= ST_RD;
          end else begin
            i     <= i + CNT_W'(1);
            state <= ST_ISTART;
          end
        end
        ST_ORD: state <= ST_OLD;
        ST_OLD: begin
          m_tvalid <= 1'b1;
          m_tlast  <= out_fin;
          m_tuser  <= out_fin && overflow;
          m_tdata  <= {{(OUT_W - DATA_W - MOVE_W - CMPT_W){1'b0}},
                       out_fin ? compare_total : CMPT_W'(0),
                       out_fin ? move_total : MOVE_W'(0),
                       rd_a};
          state    <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + CNT_W'(1);
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  `SSC_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)
  `SSC_ASSERT_IMPLY(a_pair_in_range, state == ST_RD, (j >= gap) && (gap != '0) && (j < n))
  `SSC_ASSERT_IMPLY(a_totals_on_last, m_tvalid && !m_tlast, (m_tdata[65:32] == '0) && !m_tuser)

endmodule

>>> dv/shell_sort_with_counts_checker.sv
// Checker for the shell sort block: predicts every sorted output beat and its totals.
// Watches both stream channels of the block; depends on ssc_pkg.
module shell_sort_with_counts_checker
  import ssc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [31:0]      s_tdata,  // [31:0] value
  input  logic             s_tlast,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,  // [31:0] sorted_value, [49:32] move_total,
                                     // [65:50] compare_total, [71:66] zero
  input  logic             m_tuser,  // [0] overflow
  input  logic             m_tlast,
  output int               fail_count,
  output int               pending_beats
);

  typedef struct {
    data_t             value;
    logic [MOVE_W-1:0] moves;
    logic [CMPT_W-1:0] compares;
    logic              ovf;
    logic              fin;
  } sorted_beat_t;

  data_t        run_values[$];
  logic         run_overflow;
  sorted_beat_t sorted_beats[$];

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Gonnet-gap shell sort, no early exit in the gapped chain walk
  function automatic void sort_run();
    data_t        arr[MAX_ELEMENTS];
    data_t        t;
    int           n;
    int           gap;
    int           i;
    int           j;
    int unsigned  moves;
    int unsigned  cmps;
    sorted_beat_t b;
    n = run_values.size();
    for (i = 0; i < n; i++) arr[i] = run_values[i];
    gap = n;
    moves = 0;
    cmps = 0;
    while (gap > 1) begin
      gap = (gap <= 2) ? 1 : (5 * gap) / 11;
      for (i = gap; i < n; i++) begin
        for (j = i; j >= gap; j -= gap) begin
          if (cmps < CMPT_MAX) cmps++;
          if (arr[j] < arr[j-gap]) begin
            t = arr[j];
            arr[j] = arr[j-gap];
            arr[j-gap] = t;
            moves += 3;
            if (moves > MOVE_MAX) moves = MOVE_MAX;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      b.value    = arr[i];
      b.fin      = (i == n - 1);
      b.moves    = b.fin ? moves[MOVE_W-1:0] : '0;
      b.compares = b.fin ? cmps[CMPT_W-1:0] : '0;
      b.ovf      = b.fin ? run_overflow : 1'b0;
      sorted_beats.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst) begin
      run_values.delete();
      sorted_beats.delete();
      run_overflow = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (run_values.size() < MAX_ELEMENTS) run_values.push_back(s_tdata);
        else run_overflow = 1'b1;
        if (s_tlast) begin
          sort_run();
          run_values.delete();
          run_overflow = 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (sorted_beats.size() == 0) begin
          $error("output beat with nothing expected: tdata 'h%0h", m_tdata);
          fail_count++;
        end else begin
          want = sorted_beats.pop_front();
          check_field("sorted_value", want.value, m_tdata[31:0]);
          check_field("move_total", want.moves, m_tdata[49:32]);
          check_field("compare_total", want.compares, m_tdata[65:50]);
          check_field("tdata pad", 0, m_tdata[OUT_W-1:66]);
          check_field("overflow", want.ovf, m_tuser);
          check_field("last_out", want.fin, m_tlast);
        end
      end
    end
    pending_beats = sorted_beats.size();
  end

endmodule

>>> dv/shell_sort_with_counts_tb.sv
// Testbench top for shell_sort_with_counts: reset, directed and random runs, verdict.
// Depends on ssc_pkg, shell_sort_with_counts and shell_sort_with_counts_checker.
module shell_sort_with_counts_tb;
  import ssc_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_FROM    = RANDOM_ITEMS - 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum {FILL_RANDOM, FILL_NARROW, FILL_EXTREME, FILL_DESCENDING} fill_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic             s_tlast;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             m_tlast;
  int               fail_count;
  int               pending_beats;
  int               cycle_count;
  int               random_sent;
  bit               calm;
  data_t            dir_q[$];

  shell_sort_with_counts i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  shell_sort_with_counts_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // output side stalls
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_beat(input data_t v, input logic l);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_list(input data_t q[$]);
    int k;
    for (k = 0; k < q.size(); k++) send_beat(q[k], k == q.size() - 1);
  endtask

  function automatic data_t pick_value(fill_t fill, int k, data_t base);
    case (fill)
      FILL_RANDOM: return $urandom;
      FILL_NARROW: return data_t'($urandom_range(0, 7));
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return base - data_t'(k) * 32'd977;
    endcase
  endfunction

  task automatic send_run(input int len, input fill_t fill);
    data_t base;
    int    k;
    base = $urandom;
    for (k = 0; k < len; k++) begin
      send_beat(pick_value(fill, k, base), k == len - 1);
      random_sent++;
      if (random_sent >= CALM_FROM) calm = 1'b1;
    end
  endtask

  initial begin
    int sel;
    int len;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    calm = 1'b0;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single elements, swap pair, sorted, extremes, duplicates, reversed
    dir_q = '{32'h0000_0000};
    send_list(dir_q);
    dir_q = '{32'hFFFF_FFFF};
    send_list(dir_q);
    dir_q = '{32'd5, 32'd3};
    send_list(dir_q);
    dir_q = '{32'd1, 32'd2, 32'd3};
    send_list(dir_q);
    dir_q = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFE};
    send_list(dir_q);
    dir_q = '{32'd7, 32'd7, 32'd7, 32'd7};
    send_list(dir_q);
    dir_q = '{32'd80, 32'd70, 32'd60, 32'd50, 32'd40, 32'd30, 32'd20, 32'd10};
    send_list(dir_q);

    // full store plus one: the dropped beat carries tlast
    send_run(MAX_ELEMENTS + 1, FILL_RANDOM);
    while (random_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) len = $urandom_range(1, 12);
      else if (sel < 90) len = $urandom_range(13, 40);
      else len = $urandom_range(56, 72);
      send_run(len, fill_t'($urandom_range(0, 3)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
